// ===== sv/qdd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdd_pkg
// shared types and constants for the q4 block dequantize dot product
// ----------------------------------------------------------------------------
`default_nettype none

package qdd_pkg;

	// activation width that counts (low bits of each activation field)
	localparam int ACT_W = 16;

	// q4 weight decoding
	localparam logic [3:0] NIBBLE_MASK = 4'hF;
	localparam logic signed [4:0] ZERO_POINT = 5'sd8;

	// ieee half fields
	localparam logic [4:0] HALF_EXP_MASK = 5'h1F;
	localparam logic [9:0] HALF_MANT_MASK = 10'h3FF;
	localparam logic [10:0] HALF_HIDDEN = 11'h400;
	localparam int BLOCK_WEIGHTS = 32;

	// datapath widths
	localparam int SIG_W = 11;
	localparam int SHIFT_W = 5;
	localparam int S_W = ACT_W + 5;
	localparam int P_W = S_W + SIG_W + 1;
	localparam int SH_W = (P_W + 29 > 65) ? P_W + 29 : 65;
	localparam int ACC_W = 64;

	localparam logic [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic [7:0] weight_pair;
		logic signed [15:0] act_low;
		logic signed [15:0] act_high;
		logic [15:0] block_scale;
		logic last_in_row;
	} item_t;

	typedef struct packed {
		logic signed [63:0] dot_value;
		logic saturated;
		logic bad_scale;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ALIGN,
		ST_ACCUM
	} state_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_s3;
	} ctrl_status_t;

endpackage

`default_nettype wire

// ===== sv/q4_block_dequant_dot_product.sv =====
// ----------------------------------------------------------------------------
// q4_block_dequant_dot_product
// q4 weight dequantize and dot product with an exact 64-bit accumulator
// ----------------------------------------------------------------------------
// usage
//   item channel: one transaction per packed weight byte, carrying two q4
//   weights (zero point 8), the two q7.8 activations paired with them, the raw
//   fp16 block scale and a last-in-row mark
//   result channel: one transaction per row, raised by the byte marked last;
//   dot_value is in units of 2^-32, saturated and bad_scale are sticky flags
//   over the row
// timing
//   each item goes through these steps: the accept cycle (nibble products), the
//   scale multiply, the exponent shift and clamp, and the accumulator add; the
//   controller walks one item through these steps, so item_ready is high only
//   in the idle step and no new item is taken before the last one's add
//   a result appears in the cycle after the last item's add
// reset
//   arst_n clears the accumulator, both flags and the controller; no result
//   is pending after reset
// stalls
//   the result sits in its own register, so the next row's items are taken
//   while it waits; only a second last item waits at the add step until the
//   pending result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module q4_block_dequant_dot_product
	import qdd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire item_t item,
	output logic result_valid,
	input wire logic result_ready,
	output result_t result
);

	// command and status between controller and datapath
	ctrl_cmd_t cmd;
	ctrl_status_t status;

	qdd_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status (status),
		.cmd (cmd)
	);

	qdd_datapath u_datapath (
		.clk (clk),
		.arst_n (arst_n),
		.item (item),
		.cmd (cmd),
		.status (status),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== sv/qdd_datapath.sv =====
// ----------------------------------------------------------------------------
// qdd_datapath
// nibble products, scale multiply, exponent alignment and saturating accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module qdd_datapath
	import qdd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire item_t item,
	input wire ctrl_cmd_t cmd,
	output ctrl_status_t status,
	output result_t result
);

	// stage 1: nibble products and scale decode
	logic signed [4:0] q_lo, q_hi;
	logic signed [ACT_W-1:0] a_lo, a_hi;
	logic signed [S_W-1:0] sum_c;
	logic [4:0] exp_c;
	logic [9:0] mant_c;

	logic signed [S_W-1:0] sum_s1;
	logic [SIG_W-1:0] sig_s1;
	logic [SHIFT_W-1:0] shift_s1;
	logic sign_s1, bad_s1, last_s1;

	assign q_lo = $signed({1'b0, item.weight_pair[3:0] & NIBBLE_MASK}) - ZERO_POINT;
	assign q_hi = $signed({1'b0, item.weight_pair[7:4] & NIBBLE_MASK}) - ZERO_POINT;
	assign a_lo = item.act_low[ACT_W-1:0];
	assign a_hi = item.act_high[ACT_W-1:0];
	assign sum_c = S_W'(q_lo) * S_W'(a_lo) + S_W'(q_hi) * S_W'(a_hi);
	assign exp_c = item.block_scale[14:10] & HALF_EXP_MASK;
	assign mant_c = item.block_scale[9:0] & HALF_MANT_MASK;

	always_ff @(posedge clk) begin
		if (cmd.load_s1) begin
			sum_s1 <= sum_c;
			sig_s1 <= (exp_c != '0) ? (HALF_HIDDEN + SIG_W'(mant_c)) : SIG_W'(mant_c);
			shift_s1 <= (exp_c != '0) ? exp_c - 5'd1 : '0;
			sign_s1 <= item.block_scale[15];
			bad_s1 <= (exp_c == HALF_EXP_MASK);
			last_s1 <= item.last_in_row;
		end
	end

	// stage 2: times the half significand
	logic signed [P_W-1:0] prod_s2;
	logic [SHIFT_W-1:0] shift_s2;
	logic sign_s2, bad_s2, last_s2;

	always_ff @(posedge clk) begin
		if (cmd.load_s2) begin
			prod_s2 <= P_W'(sum_s1) * $signed({1'b0, sig_s1});
			shift_s2 <= shift_s1;
			sign_s2 <= sign_s1;
			bad_s2 <= bad_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: magnitude, exponent shift and clamp to 64 bits
	logic neg_c, over_c;
	logic [P_W-1:0] mag_c;
	logic [SH_W-1:0] shifted_c;
	logic [ACC_W-1:0] lo_c, term_c;

	logic [ACC_W-1:0] term_s3;
	logic clip_s3, fault_s3, last_s3;

	assign neg_c = prod_s2[P_W-1] ^ sign_s2;
	assign mag_c = prod_s2[P_W-1] ? P_W'(-prod_s2) : P_W'(prod_s2);
	assign shifted_c = SH_W'(mag_c) << shift_s2;
	assign lo_c = shifted_c[ACC_W-1:0];
	// only minus 2^63 may use the top bit
	assign over_c = (|shifted_c[SH_W-1:ACC_W])
		|| (lo_c[ACC_W-1] && !(neg_c && lo_c[ACC_W-2:0] == '0));

	always_comb begin
		if (bad_s2) begin
			term_c = '0;
		end else if (over_c) begin
			term_c = neg_c ? S64_MIN : S64_MAX;
		end else begin
			term_c = neg_c ? ACC_W'(-lo_c) : lo_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_s3) begin
			term_s3 <= term_c;
			clip_s3 <= over_c && !bad_s2;
			fault_s3 <= bad_s2;
			last_s3 <= last_s2;
		end
	end

	assign status.last_s3 = last_s3;

	// accumulate
	logic [ACC_W-1:0] acc_q, sum_a, acc_next;
	logic clip_q, fault_q, ovf;

	assign sum_a = acc_q + term_s3;
	assign ovf = (acc_q[ACC_W-1] == term_s3[ACC_W-1]) && (sum_a[ACC_W-1] != acc_q[ACC_W-1]);
	assign acc_next = ovf ? (acc_q[ACC_W-1] ? S64_MIN : S64_MAX) : sum_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			clip_q <= 1'b0;
			fault_q <= 1'b0;
		end else if (cmd.commit) begin
			if (last_s3) begin
				acc_q <= '0;
				clip_q <= 1'b0;
				fault_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				clip_q <= clip_q | clip_s3 | ovf;
				fault_q <= fault_q | fault_s3;
			end
		end
	end

	// result register
	result_t result_q;

	always_ff @(posedge clk) begin
		if (cmd.commit && last_s3) begin
			result_q.dot_value <= $signed(acc_next);
			result_q.saturated <= clip_q | clip_s3 | ovf;
			result_q.bad_scale <= fault_q | fault_s3;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

// ===== sv/qdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// qdd_ctrl
// sequences one transaction through the datapath and owns both handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module qdd_ctrl
	import qdd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	output logic result_valid,
	input wire logic result_ready,
	input wire ctrl_status_t status,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	// result register can take a new value this cycle
	assign out_free = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_s1 = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.load_s2 = 1'b1;
				state_d = ST_ALIGN;
			end
			ST_ALIGN: begin
				cmd.load_s3 = 1'b1;
				state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				if (!status.last_s3 || out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && status.last_s3) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

	// a finished dot product never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && status.last_s3 |-> !out_valid_q || result_ready)
		else $error("result overwritten while pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> state_q == ST_MUL)
		else $error("accepted transaction not started");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_s1, cmd.load_s2, cmd.load_s3, cmd.commit}))
		else $error("more than one datapath step at once");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit && status.last_s3))
		else $error("result shown without a final commit");

endmodule

`default_nettype wire
